// File: sv/mfc_pkg.sv
// Shared constants, types and helper functions for the matched-filter correlator.
package mfc_pkg;

    // Sizing
    localparam int MAX_TAPS    = 64;
    localparam int MAX_FRAME   = 65536;
    localparam int SAMPLE_BITS = 16;

    // Field widths of the stream words
    localparam int WORD_W  = 16;
    localparam int TAPIN_W = 6;
    localparam int CFG_W   = 7;
    localparam int VALUE_W = 40;
    localparam int POS_W   = 16;

    // Derived widths
    localparam int IN_BITS  = (SAMPLE_BITS < WORD_W) ? SAMPLE_BITS : WORD_W;
    localparam int TAP_W    = $clog2(MAX_TAPS);
    localparam int LEN_W    = $clog2(MAX_TAPS + 1);
    localparam int FP_W     = $clog2(MAX_FRAME);
    localparam int PROD_W   = 2 * IN_BITS;
    localparam int ACC_NEED = PROD_W + TAP_W + 1;
    localparam int ACC_W    = (ACC_NEED > VALUE_W) ? ACC_NEED : VALUE_W;

    // Stream word layout
    localparam int S_TAP_LSB   = 0;
    localparam int S_WORD_LSB  = TAPIN_W;
    localparam int S_TDATA_W   = ((TAPIN_W + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VALUE_W + POS_W + 7) / 8) * 8;

    // Register reset value and sum limits
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);
    localparam longint SUM_MAX = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
    localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

    // Input word kinds and result kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;
    localparam logic RES_CORR    = 1'b0;
    localparam logic RES_PEAK    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CORR,
        ST_PEAK
    } state_t;

    // Controls broadcast along the cell row
    typedef struct packed {
        logic               shift;
        logic               coef_we;
        logic [TAP_W-1:0]   coef_cell;
        logic [IN_BITS-1:0] coef_data;
        logic               rotate;
        logic               clear_sum;
        logic               acc_en;
        logic [LEN_W-1:0]   len;
    } cell_ctrl_t;

    // Controls for frame position and peak tracking
    typedef struct packed {
        logic advance;
        logic update;
        logic clear;
    } peak_ctrl_t;

    // Taps in use for a register value
    function automatic logic [LEN_W-1:0] len_eff(input logic [CFG_W-1:0] c);
        logic [LEN_W-1:0] r;
        if (c == '0) begin
            r = LEN_W'(1);
        end else if (32'(c) > MAX_TAPS) begin
            r = LEN_W'(MAX_TAPS);
        end else begin
            r = LEN_W'(c);
        end
        return r;
    endfunction

    // Clamp a wide sum to the signed result range
    function automatic logic signed [VALUE_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] r;
        if (a > ACC_W'(SUM_MAX)) begin
            r = ACC_W'(SUM_MAX);
        end else if (a < ACC_W'(SUM_MIN)) begin
            r = ACC_W'(SUM_MIN);
        end else begin
            r = a;
        end
        return r[VALUE_W-1:0];
    endfunction

    // Low bits of a position as reported
    function automatic logic [POS_W-1:0] pos16(input logic [31:0] p);
        return p[POS_W-1:0];
    endfunction

endpackage

// File: sv/mfc_cell.sv
// One correlator cell: delay-line sample, template coefficient, product and partial sum.
module mfc_cell
    import mfc_pkg::*;
(
    input  logic                      aclk,
    input  cell_ctrl_t                ctl,
    input  logic [TAP_W-1:0]          cell_idx,
    input  logic signed [IN_BITS-1:0] sample_in,
    output logic signed [IN_BITS-1:0] sample_out,
    input  logic signed [IN_BITS-1:0] coef_in,
    output logic signed [IN_BITS-1:0] coef_out,
    input  logic signed [ACC_W-1:0]   psum_in,
    output logic signed [ACC_W-1:0]   psum_out
);

    logic signed [IN_BITS-1:0] sample_reg, sample_next;
    logic signed [IN_BITS-1:0] coef_reg, coef_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   psum_reg, psum_next;
    logic                      active;

    // Shift samples, load or rotate the coefficient, multiply and accumulate
    always_comb begin
        sample_next = ctl.shift ? sample_in : sample_reg;

        if (ctl.coef_we && (cell_idx == ctl.coef_cell)) begin
            coef_next = $signed(ctl.coef_data);
        end else if (ctl.rotate) begin
            coef_next = coef_in;
        end else begin
            coef_next = coef_reg;
        end

        active = LEN_W'(cell_idx) < ctl.len;
        if (active) begin
            prod_next = sample_reg * coef_reg;
        end else begin
            prod_next = '0;
        end

        if (ctl.clear_sum) begin
            psum_next = '0;
        end else if (ctl.acc_en) begin
            psum_next = psum_in + ACC_W'(prod_reg);
        end else begin
            psum_next = psum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        coef_reg   <= coef_next;
        prod_reg   <= prod_next;
        psum_reg   <= psum_next;
    end

    assign sample_out = sample_reg;
    assign coef_out   = coef_reg;
    assign psum_out   = psum_reg;

endmodule

// File: sv/mfc_peak.sv
// Frame position counter, window start index and running peak search.
module mfc_peak
    import mfc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  peak_ctrl_t                ctl,
    input  logic [LEN_W-1:0]          len,
    input  logic signed [VALUE_W-1:0] win_value,
    output logic                      win_hit,
    output logic [POS_W-1:0]          win_pos,
    output logic signed [VALUE_W-1:0] peak_value,
    output logic [POS_W-1:0]          peak_pos
);

    logic [FP_W-1:0]           pos_reg, pos_next;
    logic [FP_W-1:0]           item_idx_reg, item_idx_next;
    logic signed [VALUE_W-1:0] best_value_reg, best_value_next;
    logic [POS_W-1:0]          best_pos_reg, best_pos_next;
    logic                      best_seen_reg, best_seen_next;

    // Window present once the frame holds a full template
    assign win_hit = (32'(pos_reg) + 32'd1) >= 32'(len);
    assign win_pos = pos16(32'(item_idx_reg) + 32'd1 - 32'(len));

    // Peak report, with the trailing zero entries of the frame taken in
    always_comb begin
        peak_value = '0;
        peak_pos   = '0;
        if (best_seen_reg) begin
            if ((len > LEN_W'(1)) && best_value_reg[VALUE_W-1]) begin
                peak_pos = pos16(32'(item_idx_reg) + 32'd2 - 32'(len));
            end else begin
                peak_value = best_value_reg;
                peak_pos   = best_pos_reg;
            end
        end
    end

    // Advance position, track best window, drop all at frame end
    always_comb begin
        pos_next        = pos_reg;
        item_idx_next   = item_idx_reg;
        best_value_next = best_value_reg;
        best_pos_next   = best_pos_reg;
        best_seen_next  = best_seen_reg;
        if (ctl.advance) begin
            item_idx_next = pos_reg;
            if (pos_reg < FP_W'(MAX_FRAME - 1)) begin
                pos_next = pos_reg + FP_W'(1);
            end
        end
        if (ctl.update && (!best_seen_reg || (win_value > best_value_reg))) begin
            best_value_next = win_value;
            best_pos_next   = win_pos;
            best_seen_next  = 1'b1;
        end
        if (ctl.clear) begin
            pos_next        = '0;
            best_value_next = '0;
            best_pos_next   = '0;
            best_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            best_value_reg <= '0;
            best_pos_reg   <= '0;
            best_seen_reg  <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            best_value_reg <= best_value_next;
            best_pos_reg   <= best_pos_next;
            best_seen_reg  <= best_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_idx_reg <= item_idx_next;
    end

endmodule

// File: sv/matched_filter_correlator_peak.sv
// Top level: sliding matched-filter correlator with frame peak report.
//
// Input stream s_*: tuser selects a coefficient load (0) or a data sample (1);
// a load writes one template tap, and the block stays ready. tlast marks the
// last sample of a frame. Output stream m_*: tuser 0 is a window correlation
// with its start index, tuser 1 the peak report of a finished frame; tlast
// flags the final result word caused by one input word.
// A sample that completes a window presents its correlation word after a
// multiply step, an accumulate step in which the partial sum walks the row
// of L cells (L = taps in use) one cell per cycle, and an output step.
// The peak report at frame end follows in its own step, and the next input
// word is taken only after these steps. A sample without a full window
// needs none of them, and at frame end goes straight to the peak report.
// Words are taken one at a time; a finished result waits in the output
// register while the next input word is accepted and worked on. When the
// receiver stalls, the block holds in its result step until m_tready.
// The cfg channel is always ready. A new template length realigns the stored
// coefficients by rotating the cell ring, during which s_tready stays low.
// After reset the length is 64, the frame position and peak are clear, and
// template taps hold undefined values until loaded.
module matched_filter_correlator_peak
    import mfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Template length register
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,

    // Input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // tap_index, sample_word, zero pad
    input  logic                 s_tuser,   // kind
    input  logic                 s_tlast,   // frame_end

    // Result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result_value, result_position
    output logic                 m_tuser,   // result_kind
    output logic                 m_tlast    // last_result
);

    logic [CFG_W-1:0]          len_cfg_reg, len_cfg_next;
    logic [LEN_W-1:0]          len;
    logic [LEN_W-1:0]          align_reg, align_next;
    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          cnt_reg, cnt_next;
    logic                      last_item_reg, last_item_next;

    logic                      m_valid_reg, m_valid_next;
    logic                      m_kind_reg, m_kind_next;
    logic signed [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [POS_W-1:0]          m_pos_reg, m_pos_next;
    logic                      m_last_reg, m_last_next;

    logic                      accept;
    logic                      is_sample;
    logic                      realign;
    logic                      out_free;
    logic [TAP_W-1:0]          tap;
    logic                      tap_ok;
    logic [TAP_W:0]            tgt_diff;
    logic [TAP_W-1:0]          tgt_cell;

    cell_ctrl_t                cell_ctl;
    peak_ctrl_t                peak_ctl;
    logic                      win_hit;
    logic [POS_W-1:0]          win_pos;
    logic signed [VALUE_W-1:0] win_value;
    logic signed [VALUE_W-1:0] peak_value;
    logic [POS_W-1:0]          peak_pos;

    logic signed [IN_BITS-1:0] sample_q [MAX_TAPS];
    logic signed [IN_BITS-1:0] coef_q   [MAX_TAPS];
    logic signed [ACC_W-1:0]   psum_q   [MAX_TAPS];

    // Register write and length in use
    assign cfg_ready    = 1'b1;
    assign len_cfg_next = cfg_valid ? cfg_data : len_cfg_reg;
    assign len          = len_eff(len_cfg_reg);

    // Realign the coefficient ring until it matches the length
    assign realign    = (state_reg == ST_IDLE) && (align_reg != len);
    assign align_next = !realign ? align_reg :
                        (align_reg == LEN_W'(MAX_TAPS)) ? LEN_W'(1) :
                        align_reg + LEN_W'(1);

    // Input handshake
    assign s_tready  = (state_reg == ST_IDLE) && (align_reg == len);
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (s_tuser == KIND_SAMPLE);
    assign out_free  = !m_valid_reg || m_tready;

    // Cell that holds a tap under the current alignment
    assign tap    = TAP_W'(s_tdata[S_TAP_LSB +: TAPIN_W]);
    assign tap_ok = 32'(s_tdata[S_TAP_LSB +: TAPIN_W]) < MAX_TAPS;

    always_comb begin
        tgt_diff = (TAP_W + 1)'(align_reg - LEN_W'(1)) - (TAP_W + 1)'(tap);
        if (tgt_diff[TAP_W]) begin
            tgt_cell = TAP_W'(tgt_diff + (TAP_W + 1)'(MAX_TAPS));
        end else begin
            tgt_cell = TAP_W'(tgt_diff);
        end
    end

    // Row controls
    always_comb begin
        cell_ctl.shift     = accept && is_sample;
        cell_ctl.coef_we   = accept && !is_sample && tap_ok;
        cell_ctl.coef_cell = tgt_cell;
        cell_ctl.coef_data = s_tdata[S_WORD_LSB +: IN_BITS];
        cell_ctl.rotate    = realign;
        cell_ctl.clear_sum = (state_reg == ST_MUL);
        cell_ctl.acc_en    = (state_reg == ST_ACC);
        cell_ctl.len       = len;
    end

    // Row of cells: samples move up, partial sums move down, coefficients ring
    genvar gi;
    for (gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
        logic signed [IN_BITS-1:0] smp_in;
        logic signed [ACC_W-1:0]   sum_in;

        if (gi == 0) begin : g_head
            assign smp_in = $signed(s_tdata[S_WORD_LSB +: IN_BITS]);
        end else begin : g_body
            assign smp_in = sample_q[gi-1];
        end

        if (gi == MAX_TAPS - 1) begin : g_tail
            assign sum_in = '0;
        end else begin : g_link
            assign sum_in = psum_q[gi+1];
        end

        mfc_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .cell_idx   (TAP_W'(gi)),
            .sample_in  (smp_in),
            .sample_out (sample_q[gi]),
            .coef_in    (coef_q[(gi + MAX_TAPS - 1) % MAX_TAPS]),
            .coef_out   (coef_q[gi]),
            .psum_in    (sum_in),
            .psum_out   (psum_q[gi])
        );
    end

    assign win_value = sat_sum(psum_q[0]);

    // Frame position and peak tracking
    always_comb begin
        peak_ctl.advance = accept && is_sample;
        peak_ctl.update  = (state_reg == ST_CORR) && out_free;
        peak_ctl.clear   = (state_reg == ST_PEAK) && out_free;
    end

    mfc_peak u_peak (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (peak_ctl),
        .len        (len),
        .win_value  (win_value),
        .win_hit    (win_hit),
        .win_pos    (win_pos),
        .peak_value (peak_value),
        .peak_pos   (peak_pos)
    );

    // Sequence one sample: multiply, accumulate over L cells, emit results
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_item_next = last_item_reg;
        m_kind_next    = m_kind_reg;
        m_value_next   = m_value_reg;
        m_pos_next     = m_pos_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_sample) begin
                    last_item_next = s_tlast;
                    if (win_hit) begin
                        state_next = ST_MUL;
                    end else if (s_tlast) begin
                        state_next = ST_PEAK;
                    end
                end
            end
            ST_MUL: begin
                cnt_next   = '0;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg == len - LEN_W'(1)) begin
                    state_next = ST_CORR;
                end
            end
            ST_CORR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = RES_CORR;
                    m_value_next = win_value;
                    m_pos_next   = win_pos;
                    m_last_next  = !last_item_reg;
                    state_next   = last_item_reg ? ST_PEAK : ST_IDLE;
                end
            end
            ST_PEAK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = RES_PEAK;
                    m_value_next = peak_value;
                    m_pos_next   = peak_pos;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_cfg_reg <= CFG_RESET;
            align_reg   <= len_eff(CFG_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_cfg_reg <= len_cfg_next;
            align_reg   <= align_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        last_item_reg <= last_item_next;
        m_kind_reg    <= m_kind_next;
        m_value_reg   <= m_value_next;
        m_pos_reg     <= m_pos_next;
        m_last_reg    <= m_last_next;
    end

    // Result word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_pos_reg, m_value_reg});
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
